// ===== hw/rtl/smx_pkg.sv =====
// Shared constants and codes for the SplitMix64 ranged generator.
`default_nettype none

package smx_pkg;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int FRAC_W  = 53;
   localparam int OP_W    = 2;
   localparam int REG_W   = 2;

   // golden step and finaliser constants
   localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
   localparam int                MIX_SH_1    = 30;
   localparam int                MIX_SH_2    = 27;
   localparam int                MIX_SH_3    = 31;

   // request operations
   localparam logic [OP_W-1:0] OP_RAW   = 2'd0;
   localparam logic [OP_W-1:0] OP_INT   = 2'd1;
   localparam logic [OP_W-1:0] OP_INDEX = 2'd2;

   // configuration register indexes
   localparam logic [REG_W-1:0] REG_SEED   = 2'd0;
   localparam logic [REG_W-1:0] REG_STREAM = 2'd1;
   localparam logic [REG_W-1:0] REG_MODE   = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/smx_ifs.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
`default_nettype none

interface smx_req_if;
   import smx_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic signed [HALF_W-1:0] low_bound;
   logic signed [HALF_W-1:0] high_bound;
   logic [WORD_W-1:0]       index_count;

   modport source (output valid, operation, low_bound, high_bound, index_count,
                   input ready);
   modport sink   (input valid, operation, low_bound, high_bound, index_count,
                   output ready);
endinterface

interface smx_rsp_if;
   import smx_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [WORD_W-1:0]       raw_word;
   logic [HALF_W-1:0]       high_word;
   logic [FRAC_W-1:0]       unit_fraction;
   logic signed [HALF_W-1:0] int_result;
   logic [WORD_W-1:0]       index_result;
   logic                    drew;

   modport source (output valid, raw_word, high_word, unit_fraction, int_result,
                   index_result, drew, input ready);
   modport sink   (input valid, raw_word, high_word, unit_fraction, int_result,
                   index_result, drew, output ready);
endinterface

interface smx_csr_if;
   import smx_pkg::*;
   logic              valid;
   logic              ready;
   logic [REG_W-1:0]  index;
   logic [WORD_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smx_mul.sv =====
// Iterative 64x64 multiplier giving the low 64 product bits from one 32x32 unit.
`default_nettype none

module smx_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [smx_pkg::WORD_W-1:0] op_a,
   input  logic [smx_pkg::WORD_W-1:0] op_b,
   output logic                       done,
   output logic [smx_pkg::WORD_W-1:0] product
);
   import smx_pkg::*;

   localparam logic [1:0] STEP_LL  = 2'd0;
   localparam logic [1:0] STEP_LH  = 2'd1;
   localparam logic [1:0] STEP_HL  = 2'd2;
   localparam logic [1:0] STEP_ACC = 2'd3;

   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [WORD_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [1:0]        step_ff, step_in;
   logic [HALF_W-1:0] mul_x, mul_y;

   always_comb begin
      unique case (step_ff)
         STEP_LL: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[HALF_W-1:0];
         end
         STEP_LH: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[WORD_W-1:HALF_W];
         end
         default: begin
            mul_x = a_ff[WORD_W-1:HALF_W];
            mul_y = b_ff[HALF_W-1:0];
         end
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         busy_in = 1'b1;
         step_in = STEP_LL;
      end else if (busy_ff) begin
         prod_in = WORD_W'(mul_x) * WORD_W'(mul_y);
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            STEP_LL: ;
            STEP_LH: acc_in = prod_ff;
            default: acc_in[WORD_W-1:HALF_W] = acc_ff[WORD_W-1:HALF_W]
                                              + prod_ff[HALF_W-1:0];
         endcase
         if (step_ff == STEP_ACC) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/smx_div.sv =====
// Restoring shift-subtract remainder unit, one quotient bit per cycle.
`default_nettype none

module smx_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [smx_pkg::WORD_W-1:0] dividend,
   input  logic [smx_pkg::WORD_W-1:0] divisor,
   output logic                       done,
   output logic [smx_pkg::WORD_W-1:0] remainder
);
   import smx_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   logic [WORD_W-1:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;

   assign trial = {rem_ff, num_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[WORD_W-2:0], 1'b0};
         // keep the difference unless it went negative
         rem_in = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/splitmix64_ranged_generator_top.sv =====
// SplitMix64 generator with raw, bounded-int and index requests.
//
// Channels: req_ch takes a request (operation, bounds, count), rsp_ch returns
// exactly one response per request, csr_ch writes master seed (0), stream id
// (1) and seed mode (2). Each transaction completes when valid and ready are
// high at a rising clock edge.
// A draw advances the counter by the golden step and runs the finaliser
// through one shared 32x32 multiplier.
// A raw draw answers once the finaliser is through; a ranged draw adds the
// 64-bit remainder, one bit per cycle in the divider. A request that makes
// no draw goes from idle straight to the done state. One request is in
// flight at a time; req_ch is ready again once the response sits in the
// output register, so the next request starts while the previous response
// waits on a stalled receiver, and its own response then holds until the
// register frees. A write to one of the three registers reloads the counter:
// at once in direct mode, through the seed and mixing states in mixed mode;
// csr_ch and req_ch stay low meanwhile.
// Reset clears the state, seed, stream, mode, reload and response-valid
// registers and loads the counter with the golden step.
`default_nettype none

module splitmix64_ranged_generator_top (
   input  logic     clock,
   input  logic     reset,
   smx_req_if.sink  req_ch,
   smx_rsp_if.source rsp_ch,
   smx_csr_if.sink  csr_ch
);
   import smx_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b000_0001,
      ST_SEED = 7'b000_0010,
      ST_MIX0 = 7'b000_0100,
      ST_MIX1 = 7'b000_1000,
      ST_MIX2 = 7'b001_0000,
      ST_DIV  = 7'b010_0000,
      ST_DONE = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;

   logic [WORD_W-1:0]        ctr_ff, ctr_in, seed_ff, seed_in, stream_ff, stream_in;
   logic                     mode_ff, mode_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [HALF_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [WORD_W-1:0]        div_ff, div_in, z_ff, z_in;
   logic                     reload_ff, reload_in;
   logic signed [HALF_W-1:0] res_int_ff, res_int_in;
   logic [WORD_W-1:0]        res_idx_ff, res_idx_in;
   logic                     res_drew_ff, res_drew_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        out_raw_ff;
   logic signed [HALF_W-1:0] out_int_ff;
   logic [WORD_W-1:0]        out_idx_ff;
   logic                     out_drew_ff;

   logic              mul_start, mul_done, div_start, div_done;
   logic [WORD_W-1:0] mul_a, mul_b, mul_prod, div_rem;
   logic [WORD_W-1:0] ctr_step, fin_word;
   logic [HALF_W:0]   span;
   logic              csr_acc, csr_hit, req_acc, draw_go, out_free, out_load;

   smx_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   smx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (fin_word),
      .divisor   (div_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign csr_ch.ready = (state_ff == ST_IDLE);
   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_ch.valid;
   assign csr_acc      = csr_ch.valid && csr_ch.ready;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_hit      = (csr_ch.index == REG_SEED) || (csr_ch.index == REG_STREAM)
                         || (csr_ch.index == REG_MODE);

   assign ctr_step = ctr_ff + GOLDEN_STEP;
   assign fin_word = mul_prod ^ (mul_prod >> MIX_SH_3);
   // span of the bounds at 33 bits, reaches 2^32 for the full range
   assign span     = {req_ch.high_bound[HALF_W-1], req_ch.high_bound}
                     - {req_ch.low_bound[HALF_W-1], req_ch.low_bound} + (HALF_W+1)'(1);

   always_comb begin
      unique case (req_ch.operation)
         OP_RAW:   draw_go = 1'b1;
         OP_INT:   draw_go = req_ch.high_bound > req_ch.low_bound;
         OP_INDEX: draw_go = req_ch.index_count != '0;
         default:  draw_go = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_load = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in    = state_ff;
      ctr_in      = ctr_ff;
      seed_in     = seed_ff;
      stream_in   = stream_ff;
      mode_in     = mode_ff;
      op_in       = op_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      div_in      = div_ff;
      z_in        = z_ff;
      reload_in   = reload_ff;
      res_int_in  = res_int_ff;
      res_idx_in  = res_idx_ff;
      res_drew_in = res_drew_ff;
      mul_start   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_start   = 1'b0;

      if (csr_acc) begin
         unique case (csr_ch.index)
            REG_SEED:   seed_in   = csr_ch.data;
            REG_STREAM: stream_in = csr_ch.data;
            REG_MODE:   mode_in   = csr_ch.data[0];
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_acc && csr_hit) begin
               reload_in = 1'b1;
               if (mode_in) begin
                  ctr_in = (seed_in != '0) ? seed_in : GOLDEN_STEP;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = stream_in;
                  mul_b     = GOLDEN_STEP;
                  state_in  = ST_SEED;
               end
            end else if (req_acc) begin
               op_in       = req_ch.operation;
               lo_in       = req_ch.low_bound;
               hi_in       = req_ch.high_bound;
               div_in      = (req_ch.operation == OP_INT) ? {{(WORD_W-HALF_W-1){1'b0}}, span}
                                                          : req_ch.index_count;
               reload_in   = 1'b0;
               z_in        = '0;
               res_int_in  = '0;
               res_idx_in  = '0;
               res_drew_in = draw_go;
               if (draw_go) begin
                  ctr_in   = ctr_step;
                  z_in     = ctr_step;
                  state_in = ST_MIX0;
               end else begin
                  if (req_ch.operation == OP_INT) begin
                     res_int_in = req_ch.low_bound;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_SEED: begin
            if (mul_done) begin
               z_in     = seed_ff + mul_prod;
               state_in = ST_MIX0;
            end
         end
         ST_MIX0: begin
            mul_start = 1'b1;
            mul_a     = z_ff ^ (z_ff >> MIX_SH_1);
            mul_b     = MIX_MUL_A;
            state_in  = ST_MIX1;
         end
         ST_MIX1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_prod ^ (mul_prod >> MIX_SH_2);
               mul_b     = MIX_MUL_B;
               state_in  = ST_MIX2;
            end
         end
         ST_MIX2: begin
            if (mul_done) begin
               if (reload_ff) begin
                  ctr_in   = (fin_word != '0) ? fin_word : GOLDEN_STEP;
                  state_in = ST_IDLE;
               end else begin
                  z_in = fin_word;
                  if (op_ff == OP_RAW) begin
                     state_in = ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (op_ff == OP_INT) begin
                  res_int_in = lo_ff + div_rem[HALF_W-1:0];
               end else begin
                  res_idx_in = div_rem;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register frees
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctr_ff       <= GOLDEN_STEP;
         seed_ff      <= '0;
         stream_ff    <= '0;
         mode_ff      <= 1'b0;
         reload_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         seed_ff      <= seed_in;
         stream_ff    <= stream_in;
         mode_ff      <= mode_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      div_ff      <= div_in;
      z_ff        <= z_in;
      res_int_ff  <= res_int_in;
      res_idx_ff  <= res_idx_in;
      res_drew_ff <= res_drew_in;
      if (out_load) begin
         out_raw_ff  <= z_ff;
         out_int_ff  <= res_int_ff;
         out_idx_ff  <= res_idx_ff;
         out_drew_ff <= res_drew_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.raw_word      = out_raw_ff;
   assign rsp_ch.high_word     = out_raw_ff[WORD_W-1:WORD_W-HALF_W];
   assign rsp_ch.unit_fraction = out_raw_ff[WORD_W-1:WORD_W-FRAC_W];
   assign rsp_ch.int_result    = out_int_ff;
   assign rsp_ch.index_result  = out_idx_ff;
   assign rsp_ch.drew          = out_drew_ff;

   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_direct_load_nonzero: assert property (@(posedge clock) disable iff (reset)
      (csr_acc && csr_hit && mode_in) |=> ctr_ff != '0)
      else $error("direct reload left a zero counter");

   a_int_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (out_load && op_ff == OP_INT && res_drew_ff)
      |-> (res_int_ff >= lo_ff && res_int_ff <= hi_ff))
      else $error("bounded result outside its bounds");

   a_index_below_count: assert property (@(posedge clock) disable iff (reset)
      (out_load && op_ff == OP_INDEX && res_drew_ff) |-> res_idx_ff < div_ff)
      else $error("index result not below count");

endmodule

`default_nettype wire
